### rtl/core/mtct_pkg.sv
// shared types and codes for the multi timer countdown table
// no dependencies
package mtct_pkg;

  localparam int ID_W   = 32;
  localparam int TICK_W = 32;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_KILL = 2'd1,
    OP_TICK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_APPEND,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] rem;
  } entry_t;

  // request from the sequencer to the result stage
  typedef struct packed {
    logic            push;
    logic            finish;
    status_t         status;
    logic [ID_W-1:0] id;
  } res_req_t;

endpackage

### rtl/core/multi_timer_countdown_table_top.sv
// multi timer countdown table: set, kill and tick over an ordered timer list
// walk: set, kill and tick visit each active entry in turn (kill of id 0 skips it),
// one memory read and one evaluate step per entry through the shared unit
// throughput: one word at a time, the input stalls until the final result is loaded
// reset: rst_n clears the entry count and list head; entry memory is not cleared
// depends on mtct_pkg, mtct_store, mtct_out, mtct_ctrl
module multi_timer_countdown_table_top
  import mtct_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [ID_W-1:0]   in_timer_id,
  input  logic [TICK_W-1:0] in_elapse_ticks,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic              out_fired,
  output logic [ID_W-1:0]   out_fired_id,
  output logic              out_last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  entry_t           wdata;
  entry_t           rdata;
  res_req_t         req;
  logic             rdy;
  logic [CNT_W-1:0] count;

  mtct_store #(.SLOTS(SLOTS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  mtct_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .busy            (in_stall),
    .in_operation    (in_operation),
    .in_timer_id     (in_timer_id),
    .in_elapse_ticks (in_elapse_ticks),
    .we              (we),
    .waddr           (waddr),
    .wdata           (wdata),
    .raddr           (raddr),
    .rdata           (rdata),
    .req             (req),
    .rdy             (rdy),
    .count           (count)
  );

  mtct_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .rdy          (rdy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_fired    (out_fired),
    .out_fired_id (out_fired_id),
    .out_last     (out_last)
  );

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(SLOTS))
    else $error("entry count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off while a word is in work");

  a_idle_word_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fired) |-> (out_last && out_fired_id == '0))
    else $error("non-fired result word not final or id not cleared");

  a_fired_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fired) |-> (out_status == ST_DONE))
    else $error("fired word with error status");

endmodule

### rtl/core/mtct_store.sv
// entry memory: one write port, one read port with registered read data
// depends on mtct_pkg
module mtct_store
  import mtct_pkg::*;
#(
  parameter  int SLOTS = 16,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [IDX_W-1:0]       waddr,
  input  entry_t                 wdata,
  input  logic [IDX_W-1:0]       raddr,
  output entry_t                 rdata
);

  entry_t mem_r [SLOTS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/mtct_out.sv
// result stage: holds the latest expired id back until the walk shows whether
// it is the final word, then loads the output register; depends on mtct_pkg
module mtct_out
  import mtct_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  res_req_t        req,
  output logic            rdy,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_status,
  output logic            out_fired,
  output logic [ID_W-1:0] out_fired_id,
  output logic            out_last
);

  logic            pend_vld_r, pend_vld_nxt;
  logic [ID_W-1:0] pend_id_r, pend_id_nxt;
  logic            vld_r, vld_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            fired_r, fired_nxt;
  logic [ID_W-1:0] fid_r, fid_nxt;
  logic            last_r, last_nxt;

  assign rdy = !vld_r || !out_stall;

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    vld_nxt      = vld_r && out_stall;
    status_nxt   = status_r;
    fired_nxt    = fired_r;
    fid_nxt      = fid_r;
    last_nxt     = last_r;
    if (req.push) begin
      if (pend_vld_r) begin
        vld_nxt    = 1'b1;
        status_nxt = ST_DONE;
        fired_nxt  = 1'b1;
        fid_nxt    = pend_id_r;
        last_nxt   = 1'b0;
      end
      pend_vld_nxt = 1'b1;
      pend_id_nxt  = req.id;
    end else if (req.finish) begin
      vld_nxt  = 1'b1;
      last_nxt = 1'b1;
      if (pend_vld_r) begin
        status_nxt = ST_DONE;
        fired_nxt  = 1'b1;
        fid_nxt    = pend_id_r;
      end else begin
        status_nxt = req.status;
        fired_nxt  = 1'b0;
        fid_nxt    = '0;
      end
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      vld_r      <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      vld_r      <= vld_nxt;
    end
    pend_id_r <= pend_id_nxt;
    status_r  <= status_nxt;
    fired_r   <= fired_nxt;
    fid_r     <= fid_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid    = vld_r;
  assign out_status   = status_r;
  assign out_fired    = fired_r;
  assign out_fired_id = fid_r;
  assign out_last     = last_r;

endmodule

### rtl/core/mtct_ctrl.sv
// sequencer: walks the ring-ordered entry list from last to first through the
// shared compare and decrement unit; depends on mtct_pkg
module mtct_ctrl
  import mtct_pkg::*;
#(
  parameter  int SLOTS = 16,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   busy,
  input  logic [1:0]             in_operation,
  input  logic [ID_W-1:0]        in_timer_id,
  input  logic [TICK_W-1:0]      in_elapse_ticks,
  output logic                   we,
  output logic [IDX_W-1:0]       waddr,
  output entry_t                 wdata,
  output logic [IDX_W-1:0]       raddr,
  input  entry_t                 rdata,
  output res_req_t               req,
  input  logic                   rdy,
  output logic [CNT_W-1:0]       count
);

  function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(SLOTS)) begin
      s = s - (CNT_W+1)'(SLOTS);
    end
    return s[IDX_W-1:0];
  endfunction

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TICK_W-1:0] elapse_r, elapse_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  rm_r, rm_nxt;
  logic              found_r, found_nxt;
  logic              full_r, full_nxt;

  logic              accept;
  logic              id_match;
  logic              expire;
  logic              advance;
  logic              walk_done;
  logic [TICK_W-1:0] dec;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign id_match  = (rdata.id == id_r);
  assign expire    = (rdata.rem < TICK_W'(2));
  assign dec       = rdata.rem - TICK_W'(1);
  assign advance   = !(op_r == OP_TICK && expire) || rdy;
  assign walk_done = (k_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(in_operation) == OP_NOP ||
              (op_t'(in_operation) == OP_KILL && in_timer_id == '0)) begin
            state_nxt = S_FINISH;
          end else if (count_r == '0) begin
            state_nxt = (op_t'(in_operation) == OP_SET) ? S_APPEND : S_FINISH;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        if (advance) begin
          if (walk_done) begin
            state_nxt = (op_r == OP_SET && !found_nxt) ? S_APPEND : S_FINISH;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_APPEND: state_nxt = S_FINISH;
      S_FINISH: begin
        if (rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    op_nxt     = op_r;
    id_nxt     = id_r;
    elapse_nxt = elapse_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    rm_nxt     = rm_r;
    found_nxt  = found_r;
    full_nxt   = full_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = op_t'(in_operation);
          id_nxt     = in_timer_id;
          elapse_nxt = in_elapse_ticks;
          k_nxt      = count_r - CNT_W'(1);
          rm_nxt     = '0;
          found_nxt  = 1'b0;
          full_nxt   = 1'b0;
          if (op_t'(in_operation) == OP_KILL && in_timer_id == '0) begin
            count_nxt = '0;
          end
        end
      end
      S_EVAL: begin
        if (advance) begin
          unique case (op_r)
            OP_SET:  found_nxt = found_r || id_match;
            OP_KILL: begin
              if (id_match) begin
                rm_nxt = rm_r + CNT_W'(1);
              end
            end
            OP_TICK: begin
              if (expire) begin
                rm_nxt = rm_r + CNT_W'(1);
              end
            end
            default: ;
          endcase
          k_nxt = k_r - CNT_W'(1);
        end
      end
      S_APPEND: begin
        if (count_r < CNT_W'(SLOTS)) begin
          count_nxt = count_r + CNT_W'(1);
        end else begin
          full_nxt = 1'b1;
        end
      end
      S_FINISH: begin
        if (rdy) begin
          head_nxt  = wrap(head_r, rm_r);
          count_nxt = count_r - rm_r;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    we         = 1'b0;
    waddr      = wrap(head_r, k_r + rm_r);
    wdata      = rdata;
    raddr      = wrap(head_r, k_r);
    req        = '0;
    req.status = ST_DONE;
    unique case (state_r)
      S_EVAL: begin
        if (advance) begin
          unique case (op_r)
            OP_SET: begin
              we         = id_match;
              wdata.rem  = elapse_r;
            end
            OP_KILL: we = !id_match;
            OP_TICK: begin
              if (expire) begin
                req.push = 1'b1;
                req.id   = rdata.id;
              end else begin
                we        = 1'b1;
                wdata.rem = dec;
              end
            end
            default: ;
          endcase
        end
      end
      S_APPEND: begin
        we         = (count_r < CNT_W'(SLOTS));
        waddr      = wrap(head_r, count_r);
        wdata.id   = id_r;
        wdata.rem  = elapse_r;
      end
      S_FINISH: begin
        req.finish = rdy;
        priority if (op_r == OP_SET && full_r) begin
          req.status = ST_FULL;
        end else if (op_r == OP_KILL && id_r != '0 && rm_r == '0) begin
          req.status = ST_NOT_FOUND;
        end else begin
          req.status = ST_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    elapse_r <= elapse_nxt;
    k_r      <= k_nxt;
    rm_r     <= rm_nxt;
    found_r  <= found_nxt;
    full_r   <= full_nxt;
  end

  assign busy  = (state_r != S_IDLE);
  assign count = count_r;

endmodule

### tb/mtct_timer_checker.sv
// checker for the multi timer countdown table: mirrors the timer list, predicts
// every result word and compares it with the result channel
// depends on mtct_pkg
module mtct_timer_checker
  import mtct_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [ID_W-1:0]   in_timer_id,
  input  logic [TICK_W-1:0] in_elapse_ticks,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_status,
  input  logic              out_fired,
  input  logic [ID_W-1:0]   out_fired_id,
  input  logic              out_last,
  output int                mismatches,
  output int                words_due
);

  typedef struct packed {
    status_t         status;
    logic            fired;
    logic [ID_W-1:0] fired_id;
    logic            last;
  } timer_word_t;

  timer_word_t       expected_words[$];
  logic [ID_W-1:0]   live_id    [SLOTS];
  logic [TICK_W-1:0] live_ticks [SLOTS];
  int                live_count = 0;
  int                errors = 0;

  function automatic int find_live(input logic [ID_W-1:0] id);
    for (int i = 0; i < live_count; i++) begin
      if (live_id[i] == id) return i;
    end
    return -1;
  endfunction

  task automatic drop_live(input int pos);
    for (int j = pos; j + 1 < live_count; j++) begin
      live_id[j]    = live_id[j+1];
      live_ticks[j] = live_ticks[j+1];
    end
    if (live_count > 0) live_count--;
  endtask

  task automatic apply_timer_op(input logic [1:0] op, input logic [ID_W-1:0] id,
                                input logic [TICK_W-1:0] ticks);
    timer_word_t w;
    timer_word_t held;
    bit          have_held;
    int          pos;
    w.status   = ST_DONE;
    w.fired    = 1'b0;
    w.fired_id = '0;
    w.last     = 1'b1;
    have_held  = 1'b0;
    held       = w;
    case (op)
      OP_SET: begin
        pos = find_live(id);
        if (pos >= 0) begin
          live_ticks[pos] = ticks;
        end else if (live_count < SLOTS) begin
          live_id[live_count]    = id;
          live_ticks[live_count] = ticks;
          live_count++;
        end else begin
          w.status = ST_FULL;
        end
        expected_words.push_back(w);
      end
      OP_KILL: begin
        if (id == '0) begin
          live_count = 0;
        end else begin
          pos = find_live(id);
          if (pos >= 0) drop_live(pos);
          else w.status = ST_NOT_FOUND;
        end
        expected_words.push_back(w);
      end
      OP_TICK: begin
        // walk from the top entry down, expired ones leave the list
        for (int i = live_count - 1; i >= 0; i--) begin
          if (live_ticks[i] <= 1) begin
            if (have_held) expected_words.push_back(held);
            held.status   = ST_DONE;
            held.fired    = 1'b1;
            held.fired_id = live_id[i];
            held.last     = 1'b0;
            have_held     = 1'b1;
            drop_live(i);
          end else begin
            live_ticks[i] = live_ticks[i] - 1'b1;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          expected_words.push_back(held);
        end else begin
          expected_words.push_back(w);
        end
      end
      default: expected_words.push_back(w);
    endcase
  endtask

  always @(posedge clk) begin : watch_channels
    timer_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: status %0d fired %0d id %h last %0d",
                 out_status, out_fired, out_fired_id, out_last);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_fired !== want.fired) begin
            $error("fired: expected %0d, got %0d", want.fired, out_fired);
            errors++;
          end
          if (out_fired_id !== want.fired_id) begin
            $error("fired_id: expected %h, got %h", want.fired_id, out_fired_id);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_timer_op(in_operation, in_timer_id, in_elapse_ticks);
      end
    end else begin
      live_count = 0;
      expected_words.delete();
    end
    mismatches <= errors;
    words_due  <= expected_words.size();
  end

endmodule

### tb/multi_timer_countdown_table_top_tb.sv
// testbench top for the multi timer countdown table: drives set, kill and tick
// words with random gaps and stalls, and gives the verdict from the checker
// depends on mtct_pkg, multi_timer_countdown_table_top, mtct_timer_checker
module multi_timer_countdown_table_top_tb
  import mtct_pkg::*;
();

  localparam int SLOTS          = 16;
  localparam int POOL_SIZE      = 24;
  localparam int RANDOM_WORDS   = 85;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 2 * SLOTS + 8;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_operation;
  logic [ID_W-1:0]   in_timer_id;
  logic [TICK_W-1:0] in_elapse_ticks;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_status;
  logic              out_fired;
  logic [ID_W-1:0]   out_fired_id;
  logic              out_last;
  int                mismatches;
  int                words_due;

  bit                quiet_tx;
  bit                quiet_rx;
  bit                burst;
  bit                hold_req;
  logic [ID_W-1:0]   id_pool [POOL_SIZE];

  multi_timer_countdown_table_top #(.SLOTS(SLOTS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_timer_id     (in_timer_id),
    .in_elapse_ticks (in_elapse_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_fired       (out_fired),
    .out_fired_id    (out_fired_id),
    .out_last        (out_last)
  );

  mtct_timer_checker #(.SLOTS(SLOTS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_timer_id     (in_timer_id),
    .in_elapse_ticks (in_elapse_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_fired       (out_fired),
    .out_fired_id    (out_fired_id),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .words_due       (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_word(input op_t op, input logic [ID_W-1:0] id,
                           input logic [TICK_W-1:0] ticks);
    int gap;
    gap = (quiet_tx || burst) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_timer_id     <= id;
    in_elapse_ticks <= ticks;
    do @(posedge clk); while (in_stall);
  endtask

  // result side
  initial begin : drain_results
    int gap;
    bit hold_done;
    out_stall = 1'b0;
    quiet_rx  = 1'b0;
    hold_done = 1'b0;
    forever begin
      if ($urandom_range(0, 11) == 0) quiet_rx = !quiet_rx;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = quiet_rx ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("multi_timer_countdown_table_top test failed");
    $finish;
  end

  initial begin : stimulus
    int              pick;
    logic [ID_W-1:0] pool_id;
    in_valid        = 1'b0;
    in_operation    = OP_NOP;
    in_timer_id     = '0;
    in_elapse_ticks = '0;
    rst_n           = 1'b0;
    quiet_tx        = 1'b0;
    burst           = 1'b0;
    hold_req        = 1'b0;
    for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = (k < 4) ? k + 1 : $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, then extremes, restart in place, unused operation
    send_word(OP_TICK, 32'h0, 32'h0);
    send_word(OP_KILL, 32'h0, 32'h0);
    send_word(OP_KILL, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_SET, 32'h0, 32'h0);
    send_word(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_SET, 32'hFFFF_FFFF, 32'h2);
    send_word(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_TICK, 32'h0, 32'h0);
    send_word(OP_KILL, 32'hFFFF_FFFF, 32'h0);
    // fill the list, overflow it, then expire everything in one tick
    for (int k = 0; k < SLOTS; k++) send_word(OP_SET, 32'hA5A5_0000 + k, k % 2);
    send_word(OP_SET, 32'h5A5A_FFFF, 32'h3);
    send_word(OP_TICK, 32'h0, 32'h0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 40) begin
        hold_req = 1'b1;
        burst    = 1'b1;
      end
      if (n == 64) burst = 1'b0;
      if ($urandom_range(0, 11) == 0) quiet_tx = !quiet_tx;
      if ($urandom_range(0, 15) == 0) id_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
      pool_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick    = $urandom_range(0, 99);
      if (pick < 45) begin
        send_word(OP_SET, pool_id,
                  ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6));
      end else if (pick < 75) begin
        send_word(OP_TICK, $urandom, $urandom);
      end else if (pick < 93) begin
        send_word(OP_KILL, ($urandom_range(0, 3) == 0) ? $urandom : pool_id, $urandom);
      end else if (pick < 96) begin
        send_word(OP_KILL, 32'h0, $urandom);
      end else begin
        send_word(OP_NOP, $urandom, $urandom);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("multi_timer_countdown_table_top test passed");
    end else begin
      $display("multi_timer_countdown_table_top test failed");
    end
    $finish;
  end

endmodule
